// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, clocked, disabled during reset.
`define MDFA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define MDFA_ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/mdfa_pkg.sv -----
// Shared types and constants for the match distance filter/average block.
// No dependencies.
package mdfa_pkg;

  localparam int MAX_MATCHES_DEF = 1024;
  localparam int DIST_W          = 32;
  localparam int SCALE_W         = 16;
  localparam int PROD_W          = DIST_W + SCALE_W;
  localparam int FRAC_SHIFT      = 8;
  localparam int CNT_OUT_W       = 11;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd768;      // 3.0 in Q8.8
  localparam logic [DIST_W-1:0]  MIN_RESET   = 32'd6553600;  // 100.0 in Q16.16

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MULT,
    ST_SCAN,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ----- hw/rtl/mdfa_buffer.sv -----
// Distance store: one write port, one registered read port.
// Depends on nothing but its parameters.
module mdfa_buffer #(
  parameter int DEPTH = 1024,
  parameter int DW    = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/mdfa_divider.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module mdfa_divider #(
  parameter int NUM_W = 43,
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DEN_W:0]    rem;
  logic [DEN_W:0]    shifted;
  logic [DEN_W:0]    rem_next;
  logic              q_bit;

  always_comb begin
    shifted  = {rem[DEN_W-1:0], quotient[NUM_W-1]};
    q_bit    = (shifted >= {1'b0, divisor});
    rem_next = q_bit ? (shifted - {1'b0, divisor}) : shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(NUM_W);
      end else if (busy) begin
        step <= step - STEP_W'(1);
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[NUM_W-2:0], q_bit};
      rem      <= rem_next;
    end
  end

endmodule

// ----- hw/rtl/match_distance_filter_average.sv -----
// Minimum-distance match filter with average. Distances (unsigned Q16.16) arrive one request
// per cycle on the s_ side while s_tready is high and are stored while the smallest one is
// tracked (it starts at 100.0). The request with s_tlast high ends the set: the block then
// multiplies the minimum by the Q8.8 scale register once, rescans the buffer one entry per
// cycle counting and summing the distances whose value times 256 is strictly below that
// product, and divides the sum by the number of stored distances with a bit-serial divider.
// One summary request leaves on the m_ side. From the closing request until the result is
// loaded s_tready stays low, and longer while an earlier result is still waiting; the rescan
// is bound by the single buffer read port and the divider yields one quotient bit per cycle
// over a dividend of 32 + clog2(MAX_MATCHES+1) bits, 43 at the default size.
// A distance past MAX_MATCHES is dropped and flagged in overflow_flag; a set that stored
// nothing reports zero average and empty_flag. The result waits in an output register, so
// the next set may load while it is not yet taken.
module match_distance_filter_average
  import mdfa_pkg::*;
#(
  parameter int MAX_MATCHES = MAX_MATCHES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration: distance scale, Q8.8
  input  logic               cfg_wr_en,
  input  logic [SCALE_W-1:0] cfg_wr_data,
  // input stream
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [31:0]        s_tdata,  // [31:0] distance
  input  logic               s_tlast,  // last distance of the set
  // result stream
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [87:0]        m_tdata,  // [31:0] average_distance, [42:32] good_count,
                                       // [53:43] total_count, [85:54] threshold, rest zero
  output logic [1:0]         m_tuser   // [0] overflow_flag, [1] empty_flag
);

  localparam int CW    = $clog2(MAX_MATCHES + 1);
  localparam int AW    = $clog2(MAX_MATCHES);
  localparam int SUM_W = DIST_W + CW;

  state_t state, state_next;

  // set state
  logic [CW-1:0]      count;
  logic [DIST_W-1:0]  run_min;
  logic               ovf;
  logic [SCALE_W-1:0] scale;

  // rescan
  logic [PROD_W-1:0]  product;
  logic [CW-1:0]      idx;
  logic               rd_valid;
  logic [DIST_W-1:0]  rd_data;
  logic [SUM_W-1:0]   sum;
  logic [CW-1:0]      good;
  logic               scan_done;

  // controls
  logic               ld_accept;
  logic               buf_we;
  logic               rd_en;
  logic               div_start;
  logic               div_done;
  logic               out_load;
  logic [SUM_W-1:0]   quotient;

  // result fields
  logic [DIST_W-1:0]  thr;
  logic [DIST_W-1:0]  avg;
  logic               empty;

  mdfa_buffer #(
    .DEPTH (MAX_MATCHES),
    .DW    (DIST_W),
    .AW    (AW)
  ) u_buffer (
    .clk     (clk),
    .wr_en   (buf_we),
    .wr_addr (count[AW-1:0]),
    .wr_data (s_tdata[DIST_W-1:0]),
    .rd_en   (rd_en),
    .rd_addr (idx[AW-1:0]),
    .rd_data (rd_data)
  );

  mdfa_divider #(
    .NUM_W (SUM_W),
    .DEN_W (CW)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (count),
    .done     (div_done),
    .quotient (quotient)
  );

  // scan is over once every stored entry has been read and folded in
  assign scan_done = (idx >= count) && !rd_valid;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (s_tvalid && s_tlast) begin
          state_next = ST_MULT;
        end
      end
      ST_MULT: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // control outputs
  always_comb begin
    s_tready  = (state == ST_LOAD);
    ld_accept = s_tvalid && s_tready;
    buf_we    = ld_accept && (count < CW'(MAX_MATCHES));
    rd_en     = (state == ST_SCAN) && (idx < count);
    div_start = (state == ST_SCAN) && scan_done;
    out_load  = (state == ST_OUT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      scale <= cfg_wr_data;
    end
  end

  // set state: fill count, running minimum, drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      run_min <= MIN_RESET;
      ovf     <= 1'b0;
    end else if (out_load) begin
      count   <= '0;
      run_min <= MIN_RESET;
      ovf     <= 1'b0;
    end else if (buf_we) begin
      count <= count + CW'(1);
      if (s_tdata[DIST_W-1:0] < run_min) begin
        run_min <= s_tdata[DIST_W-1:0];
      end
    end else if (ld_accept) begin
      ovf <= 1'b1;
    end
  end

  // rescan sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      if (state == ST_MULT) begin
        idx <= '0;
      end else if (rd_en) begin
        idx <= idx + CW'(1);
      end
    end
  end

  // full product kept so the compare is exact; sum and good count of the rescan
  always_ff @(posedge clk) begin
    if (state == ST_MULT) begin
      product <= PROD_W'(run_min) * PROD_W'(scale);
      sum     <= '0;
      good    <= '0;
    end else if (rd_valid) begin
      if ((PROD_W'(rd_data) << FRAC_SHIFT) < product) begin
        sum  <= sum + SUM_W'(rd_data);
        good <= good + CW'(1);
      end
    end
  end

  // threshold output: product >> 8, saturated to 32 bits
  always_comb begin
    if (|product[PROD_W-1:DIST_W+FRAC_SHIFT]) begin
      thr = '1;
    end else begin
      thr = product[DIST_W+FRAC_SHIFT-1:FRAC_SHIFT];
    end
    empty = (count == '0);
    avg   = empty ? '0 : quotient[DIST_W-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b00, thr, CNT_OUT_W'(count), CNT_OUT_W'(good), avg};
      m_tuser <= {empty, ovf};
    end
  end

endmodule

// ----- hw/rtl/mdfa_checker.sv -----
// Port-level checks for match_distance_filter_average, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module mdfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata,
  input logic [1:0]  m_tuser
);

  `MDFA_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  `MDFA_ASSERT(a_busy_after_last, clk, rst, s_tvalid && s_tready && s_tlast |=> !s_tready, "accepting during rescan")
  `MDFA_ASSERT(a_empty_zero, clk, rst, m_tvalid && m_tuser[1] |-> m_tdata[42:0] == 43'd0, "empty set with nonzero average or count")
  `MDFA_ASSERT(a_good_le_total, clk, rst, m_tvalid |-> m_tdata[42:32] <= m_tdata[53:43], "good count above total")
  `MDFA_ASSERT_ANY(a_reset_idle, clk, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind match_distance_filter_average mdfa_checker u_mdfa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
